### design/kce_pkg.sv
// Shared types, constants and helpers of the keyframe channel evaluator.
package kce_pkg;

  localparam int MAX_KEYS_DEFAULT      = 64;
  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXTRAP_BEFORE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTRAP_AFTER  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT     = 2'd2;

  localparam logic [2:0] EXT_CONSTANT     = 3'd0;
  localparam logic [2:0] EXT_LINEAR       = 3'd1;
  localparam logic [2:0] EXT_CYCLE        = 3'd2;
  localparam logic [2:0] EXT_CYCLE_OFFSET = 3'd3;
  localparam logic [2:0] EXT_BOUNCE       = 3'd4;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_EVALUATE = 1'b1;

  localparam int DIV_REM_W = 35;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [64:0] OFS_LIMIT = 65'd1 << 34;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_EVALUATE = 2'd1,
    OP_SKIP     = 2'd2
  } kce_op_t;

  typedef struct packed {
    logic               command;
    logic [5:0]         key_index;
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] slope_in;
    logic signed [31:0] slope_out;
    logic signed [31:0] cubic_a;
    logic signed [31:0] square_b;
    logic signed [31:0] linear_c;
    logic signed [31:0] offset_d;
    logic signed [31:0] query_time;
  } kce_in_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic               saturated;
  } kce_out_t;

  typedef struct packed {
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] slope_in;
    logic signed [31:0] slope_out;
    logic signed [31:0] cubic_a;
    logic signed [31:0] square_b;
    logic signed [31:0] linear_c;
    logic signed [31:0] offset_d;
  } kce_key_t;

  typedef struct packed {
    kce_op_t op;
    kce_in_t data;
  } kce_req_t;

  typedef struct packed {
    logic [2:0] extrap_before;
    logic [2:0] extrap_after;
    logic [6:0] key_count;
  } kce_cfg_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

### design/kce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = kce_pkg::MAX_KEYS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/kce_front.sv
// Request front end: classifies incoming requests and queues them for the evaluator.
module kce_front #(
  parameter int MAX_KEYS = kce_pkg::MAX_KEYS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  kce_pkg::kce_in_t  in_data,
  output logic              req_valid,
  output kce_pkg::kce_req_t req,
  input  logic              req_pop
);
  import kce_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  kce_req_t         entry [QUEUE_DEPTH];
  kce_req_t         incoming;
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     fill;
  logic             push;
  logic             pop;

  always_comb begin
    incoming.data = in_data;
    if (in_data.command == CMD_EVALUATE) begin
      incoming.op = OP_EVALUATE;
    end else if (32'(in_data.key_index) < 32'(MAX_KEYS)) begin
      incoming.op = OP_LOAD;
    end else begin
      incoming.op = OP_SKIP;
    end
  end

  assign in_stall  = (fill == (QAW+1)'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign req_valid = (fill != '0);
  assign pop       = req_pop && req_valid;
  assign req       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

### design/kce_div.sv
// Bit-serial restoring divider giving one quotient bit per cycle.
module kce_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kce_pkg::DIV_REM_W-1:0] rem_init,
  input  logic [kce_pkg::DIV_Q_W-1:0]   dividend,
  input  logic [kce_pkg::DIV_REM_W-1:0] divisor,
  input  logic [kce_pkg::DIV_CNT_W-1:0] steps,
  output logic                          busy,
  output logic [kce_pkg::DIV_Q_W-1:0]   quotient,
  output logic [kce_pkg::DIV_REM_W-1:0] remainder
);
  import kce_pkg::*;

  logic [DIV_REM_W-1:0] rem;
  logic [DIV_REM_W-1:0] trial;
  logic [DIV_REM_W-1:0] divisor_q;
  logic [DIV_Q_W-1:0]   dsr;
  logic [DIV_Q_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 take;

  assign trial     = {rem[DIV_REM_W-2:0], dsr[DIV_Q_W-1]};
  assign take      = (trial >= divisor_q);
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem       <= rem_init;
      dsr       <= dividend;
      quo       <= '0;
      divisor_q <= divisor;
      cnt       <= steps;
      busy      <= (steps != '0);
    end else if (busy) begin
      rem <= take ? trial - divisor_q : trial;
      dsr <= {dsr[DIV_Q_W-2:0], 1'b0};
      quo <= {quo[DIV_Q_W-2:0], take};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

### design/kce_back.sv
// Evaluator back end: key store, segment search, extrapolation and cubic evaluation.
module kce_back #(
  parameter int MAX_KEYS      = kce_pkg::MAX_KEYS_DEFAULT,
  parameter int FRACTION_BITS = kce_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  kce_pkg::kce_cfg_t cfg,
  input  logic              req_valid,
  input  kce_pkg::kce_req_t req,
  output logic              req_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output kce_pkg::kce_out_t out_data
);
  import kce_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int F  = FRACTION_BITS;
  localparam int UW = F + 1;
  localparam int PW = 32 + UW + 1;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_FIRST = 20'h00002,
    S_LAST  = 20'h00004,
    S_LIN   = 20'h00008,
    S_LIN2  = 20'h00010,
    S_MOD   = 20'h00020,
    S_WRAP  = 20'h00040,
    S_SRCH  = 20'h00080,
    S_CMP   = 20'h00100,
    S_HIRD  = 20'h00200,
    S_SEGA  = 20'h00400,
    S_SEGB  = 20'h00800,
    S_UDIV  = 20'h01000,
    S_POLY1 = 20'h02000,
    S_POLY2 = 20'h04000,
    S_POLY3 = 20'h08000,
    S_POLY4 = 20'h10000,
    S_OFS   = 20'h20000,
    S_OFS2  = 20'h40000,
    S_OUT   = 20'h80000
  } kce_state_t;

  kce_state_t state;
  kce_state_t after_val;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  kce_key_t                    ram_wdata;
  logic [$bits(kce_key_t)-1:0] ram_rdata;
  kce_key_t                    rd_key;

  logic                 div_start;
  logic [DIV_REM_W-1:0] div_rem_init;
  logic [DIV_Q_W-1:0]   div_dividend;
  logic [DIV_REM_W-1:0] div_divisor;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_busy;
  logic [DIV_Q_W-1:0]   div_q;
  logic [DIV_REM_W-1:0] div_rem;

  logic signed [31:0] tq;
  logic [CW-1:0]      n;
  logic signed [31:0] t0;
  logic signed [31:0] v0;
  logic signed [31:0] tl;
  logic signed [31:0] vl;
  logic signed [31:0] slope_first;
  logic signed [31:0] slope_last;
  logic [31:0]        d;
  logic signed [32:0] span;
  logic signed [32:0] dv;
  logic               is_before;
  logic [2:0]         mode;
  logic               apply_ofs;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic signed [31:0] ti;
  logic signed [31:0] vi;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_d;
  logic [UW-1:0]      u;
  logic [UW-1:0]      u2;
  logic [UW-1:0]      u3;
  logic signed [PW-1:0] pa;
  logic signed [PW-1:0] pb;
  logic signed [PW-1:0] pc;
  logic signed [64:0] lin_prod;
  logic [32:0]        kq;
  logic [64:0]        off_prod;
  logic signed [63:0] val;

  logic [CW-1:0]      n_c;
  logic [AW-1:0]      last_addr;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid;
  logic signed [32:0] span_c;
  logic               in_range_c;
  logic               is_before_c;
  logic [2:0]         mode_raw;
  logic               wrap_raw;
  logic [2:0]         mode_c;
  logic signed [32:0] d_wide;
  logic signed [32:0] dt_c;
  logic signed [32:0] num_c;
  logic signed [34:0] r35;
  logic signed [34:0] sp35;
  logic signed [34:0] t0_35;
  logic signed [34:0] tl_35;
  logic signed [34:0] w35;
  logic               rem_nz;
  logic [2*UW-1:0]    uu;
  logic [2*UW-1:0]    u2u;
  logic signed [64:0] lin_sh;
  logic signed [63:0] pa_sh;
  logic signed [63:0] pb_sh;
  logic signed [63:0] pc_sh;
  logic signed [32:0] dv_abs;
  logic [31:0]        mag;
  logic signed [63:0] off_cap;
  logic signed [63:0] off_signed;
  logic               sat_hi;
  logic               sat_lo;
  logic               out_free;

  kce_ram #(
    .WIDTH ($bits(kce_key_t)),
    .DEPTH (MAX_KEYS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kce_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .rem_init  (div_rem_init),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign rd_key = kce_key_t'(ram_rdata);

  always_comb begin
    if (cfg.key_count == 7'd0) begin
      n_c = CW'(1);
    end else if (32'(cfg.key_count) > 32'(MAX_KEYS)) begin
      n_c = CW'(MAX_KEYS);
    end else begin
      n_c = CW'(cfg.key_count);
    end
  end

  assign last_addr = AW'(n - CW'(1));
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[AW:1];

  assign span_c      = $signed({rd_key.key_time[31], rd_key.key_time}) - $signed({t0[31], t0});
  assign in_range_c  = (tq >= t0) && (tq <= rd_key.key_time);
  assign is_before_c = (tq < t0);
  assign mode_raw    = is_before_c ? cfg.extrap_before : cfg.extrap_after;
  assign wrap_raw    = (mode_raw == EXT_CYCLE) || (mode_raw == EXT_CYCLE_OFFSET) ||
                       (mode_raw == EXT_BOUNCE);
  assign mode_c      = (wrap_raw && span_c <= 0) ? EXT_CONSTANT : mode_raw;
  assign d_wide      = is_before_c ?
                       $signed({t0[31], t0}) - $signed({tq[31], tq}) :
                       $signed({tq[31], tq}) - $signed({rd_key.key_time[31], rd_key.key_time});

  assign dt_c  = $signed({rd_key.key_time[31], rd_key.key_time}) - $signed({ti[31], ti});
  assign num_c = $signed({tq[31], tq}) - $signed({ti[31], ti});

  assign r35    = $signed({1'b0, div_rem[DIV_REM_W-2:0]});
  assign sp35   = $signed({{2{span[32]}}, span});
  assign t0_35  = $signed({{3{t0[31]}}, t0});
  assign tl_35  = $signed({{3{tl[31]}}, tl});
  assign rem_nz = (div_rem != '0);

  always_comb begin
    if (mode == EXT_BOUNCE) begin
      if (is_before) begin
        w35 = (r35 <= sp35) ? t0_35 + r35 : t0_35 + (sp35 <<< 1) - r35;
      end else begin
        w35 = (r35 <= sp35) ? tl_35 - r35 : tl_35 - ((sp35 <<< 1) - r35);
      end
    end else if (is_before) begin
      w35 = rem_nz ? t0_35 + sp35 - r35 : t0_35;
    end else begin
      w35 = rem_nz ? t0_35 + r35 : tl_35;
    end
  end

  assign uu     = u * u;
  assign u2u    = u2 * u;
  assign lin_sh = lin_prod >>> F;
  assign pa_sh  = 64'(pa >>> F);
  assign pb_sh  = 64'(pb >>> F);
  assign pc_sh  = 64'(pc >>> F);

  assign dv_abs     = dv[32] ? -dv : dv;
  assign mag        = dv_abs[31:0];
  assign off_cap    = (off_prod > OFS_LIMIT) ? 64'(OFS_LIMIT) : 64'(off_prod);
  assign off_signed = dv[32] ? -off_cap : off_cap;

  assign after_val = apply_ofs ? S_OFS : S_OUT;
  assign sat_hi    = (val > SAT_MAX);
  assign sat_lo    = (val < SAT_MIN);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = AW'(req.data.key_index);
    ram_wdata    = '{key_time:  req.data.key_time,
                     key_value: req.data.key_value,
                     slope_in:  req.data.slope_in,
                     slope_out: req.data.slope_out,
                     cubic_a:   req.data.cubic_a,
                     square_b:  req.data.square_b,
                     linear_c:  req.data.linear_c,
                     offset_d:  req.data.offset_d};
    ram_raddr    = '0;
    req_pop      = 1'b0;
    div_start    = 1'b0;
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          ram_we  = (req.op == OP_LOAD);
        end
      end
      S_FIRST: begin
        ram_raddr = last_addr;
      end
      S_LAST: begin
        if (!in_range_c && (mode_c == EXT_CYCLE || mode_c == EXT_CYCLE_OFFSET ||
                            mode_c == EXT_BOUNCE)) begin
          div_start    = 1'b1;
          div_dividend = d_wide[31:0];
          div_steps    = DIV_CNT_W'(DIV_Q_W);
          div_divisor  = (mode_c == EXT_BOUNCE) ?
                         DIV_REM_W'({span_c[32:0], 1'b0}) : DIV_REM_W'(span_c);
        end
      end
      S_SRCH: begin
        ram_raddr = (lo == mid) ? hi : mid;
      end
      S_HIRD: begin
        ram_raddr = lo;
      end
      S_SEGA: begin
        ram_raddr = lo + 1'b1;
      end
      S_SEGB: begin
        if (dt_c > 0 && num_c > 0 && num_c < dt_c) begin
          div_start    = 1'b1;
          div_rem_init = DIV_REM_W'(num_c);
          div_divisor  = DIV_REM_W'(dt_c);
          div_steps    = DIV_CNT_W'(F);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid && req.op == OP_EVALUATE) begin
            tq    <= req.data.query_time;
            n     <= n_c;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          t0          <= rd_key.key_time;
          v0          <= rd_key.key_value;
          slope_first <= rd_key.slope_in;
          state       <= S_LAST;
        end
        S_LAST: begin
          tl         <= rd_key.key_time;
          vl         <= rd_key.key_value;
          slope_last <= rd_key.slope_out;
          is_before  <= is_before_c;
          span       <= span_c;
          dv         <= $signed({rd_key.key_value[31], rd_key.key_value}) -
                        $signed({v0[31], v0});
          d          <= d_wide[31:0];
          mode       <= mode_c;
          apply_ofs  <= !in_range_c && (mode_c == EXT_CYCLE_OFFSET);
          lo         <= '0;
          hi         <= last_addr;
          if (in_range_c) begin
            if (n == CW'(1)) begin
              val   <= sx64(v0);
              state <= S_OUT;
            end else begin
              state <= S_SRCH;
            end
          end else begin
            case (mode_c)
              EXT_CONSTANT: begin
                val   <= is_before_c ? sx64(v0) : sx64(rd_key.key_value);
                state <= S_OUT;
              end
              EXT_LINEAR: begin
                state <= S_LIN;
              end
              EXT_CYCLE, EXT_CYCLE_OFFSET, EXT_BOUNCE: begin
                state <= S_MOD;
              end
              default: begin
                val   <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_LIN: begin
          lin_prod <= (is_before ? slope_first : slope_last) * $signed({1'b0, d});
          state    <= S_LIN2;
        end
        S_LIN2: begin
          val   <= is_before ? sx64(v0) - 64'(lin_sh) : sx64(vl) + 64'(lin_sh);
          state <= S_OUT;
        end
        S_MOD: begin
          if (!div_busy) begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          tq    <= w35[31:0];
          kq    <= {1'b0, div_q} + 33'(rem_nz);
          state <= S_SRCH;
        end
        S_SRCH: begin
          state <= (lo == mid) ? S_HIRD : S_CMP;
        end
        S_CMP: begin
          if (tq > rd_key.key_time) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_HIRD: begin
          if (tq == rd_key.key_time) begin
            val   <= sx64(rd_key.key_value);
            state <= after_val;
          end else begin
            state <= S_SEGA;
          end
        end
        S_SEGA: begin
          ti     <= rd_key.key_time;
          vi     <= rd_key.key_value;
          coef_a <= rd_key.cubic_a;
          coef_b <= rd_key.square_b;
          coef_c <= rd_key.linear_c;
          coef_d <= rd_key.offset_d;
          if (tq == rd_key.key_time) begin
            val   <= sx64(rd_key.key_value);
            state <= after_val;
          end else begin
            state <= S_SEGB;
          end
        end
        S_SEGB: begin
          if (dt_c <= 0) begin
            val   <= sx64(vi);
            state <= after_val;
          end else if (num_c <= 0) begin
            u     <= '0;
            state <= S_POLY1;
          end else if (num_c >= dt_c) begin
            u     <= {1'b1, {F{1'b0}}};
            state <= S_POLY1;
          end else begin
            state <= S_UDIV;
          end
        end
        S_UDIV: begin
          if (!div_busy) begin
            u     <= UW'(div_q);
            state <= S_POLY1;
          end
        end
        S_POLY1: begin
          u2    <= UW'(uu >> F);
          state <= S_POLY2;
        end
        S_POLY2: begin
          u3    <= UW'(u2u >> F);
          state <= S_POLY3;
        end
        S_POLY3: begin
          pa    <= coef_a * $signed({1'b0, u3});
          pb    <= coef_b * $signed({1'b0, u2});
          pc    <= coef_c * $signed({1'b0, u});
          state <= S_POLY4;
        end
        S_POLY4: begin
          val   <= pa_sh + pb_sh + pc_sh + sx64(coef_d);
          state <= after_val;
        end
        S_OFS: begin
          off_prod <= kq * mag;
          state    <= S_OFS2;
        end
        S_OFS2: begin
          val   <= is_before ? val - off_signed : val + off_signed;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data.saturated   <= sat_hi || sat_lo;
            out_data.curve_value <= sat_hi ? 32'sh7FFF_FFFF :
                                    sat_lo ? 32'sh8000_0000 : val[31:0];
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_MOD || state == S_UDIV))
    else $error("Divider is running outside a divide wait state.");

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("Divider restarted while still busy.");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH || state == S_CMP) |-> (lo < hi))
    else $error("Segment search bounds have crossed.");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("A result was dropped while the output register was occupied.");
endmodule

### design/keyframe_channel_evaluator_top.sv
// Top level of the keyframe channel evaluator with its configuration registers.
// A load request writes one key into the key memory as it leaves the input queue. An
// evaluate request runs a binary search that reads the single read port of the key memory in
// an address state and a compare state per step, and the segment fraction comes from a
// bit-serial divider at one bit per cycle. Cycle, cycle with offset and bounce extrapolation
// first run the 32-bit modulo on the same divider, and the offset adds the states S_OFS and
// S_OFS2. Two requests can wait in the input queue, and a finished result waits in the output
// register while the next request is already being worked on.
module keyframe_channel_evaluator_top #(
  parameter int MAX_KEYS      = kce_pkg::MAX_KEYS_DEFAULT,
  parameter int FRACTION_BITS = kce_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kce_pkg::kce_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kce_pkg::kce_out_t              out_data,
  input  logic                           cfg_write,
  input  logic [kce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kce_pkg::*;

  kce_cfg_t cfg;
  kce_req_t req;
  logic     req_valid;
  logic     req_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extrap_before <= EXT_CONSTANT;
      cfg.extrap_after  <= EXT_CONSTANT;
      cfg.key_count     <= 7'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXTRAP_BEFORE: cfg.extrap_before <= cfg_data[2:0];
        CFG_EXTRAP_AFTER:  cfg.extrap_after  <= cfg_data[2:0];
        CFG_KEY_COUNT:     cfg.key_count     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  kce_front #(
    .MAX_KEYS (MAX_KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  kce_back #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

### dv/keyframe_channel_evaluator_top_test.sv
// Self-checking testbench of the keyframe channel evaluator with its own curve predictor.
module keyframe_channel_evaluator_top_test;
  import kce_pkg::*;

  localparam int NKEYS = 64;
  localparam int FB    = 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  kce_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  kce_out_t               out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  longint   key_times [NKEYS];
  longint   key_values [NKEYS];
  longint   key_slopes_in [NKEYS];
  longint   key_slopes_out [NKEYS];
  longint   key_coefs [NKEYS][4];
  int       mode_before;
  int       mode_after;
  int       keys_in_use;
  kce_out_t expected_values [$];
  int       mismatches = 0;
  bit       quiet = 1'b0;
  bit       hold_pending = 1'b0;
  int       hold_left = 0;
  int       stall_left = 0;

  keyframe_channel_evaluator_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic longint floor_shift(longint x);
    return x >>> FB;
  endfunction

  function automatic longint segment_value(int n, longint t);
    int     lo;
    int     hi;
    int     mid;
    int     idx;
    longint dt;
    longint num;
    longint u;
    longint u2;
    longint u3;
    lo = 0;
    hi = n - 1;
    if (n == 1) return key_values[0];
    forever begin
      mid = (lo + hi) / 2;
      if (lo == mid) begin
        idx = (t == key_times[hi]) ? hi : lo;
        break;
      end
      if (t > key_times[mid]) lo = mid; else hi = mid;
    end
    if (t == key_times[idx]) return key_values[idx];
    dt = key_times[idx + 1] - key_times[idx];
    if (dt <= 0) return key_values[idx];
    num = t - key_times[idx];
    u = (num <= 0) ? 0 : (num <<< FB) / dt;
    if (u > (64'sd1 <<< FB)) u = 64'sd1 <<< FB;
    u2 = (u * u) >>> FB;
    u3 = (u2 * u) >>> FB;
    return floor_shift(key_coefs[idx][0] * u3) + floor_shift(key_coefs[idx][1] * u2)
         + floor_shift(key_coefs[idx][2] * u) + key_coefs[idx][3];
  endfunction

  function automatic longint span_offset(longint k, longint dv);
    longint limit;
    longint mag;
    longint p;
    limit = 64'sd1 <<< 34;
    mag = (dv < 0) ? -dv : dv;
    if (mag == 0) return 0;
    p = (k > limit / mag) ? limit : k * mag;
    return (dv < 0) ? -p : p;
  endfunction

  function automatic longint curve_value_at(longint t);
    int     n;
    int     mode;
    bit     early;
    longint t0;
    longint tl;
    longint span;
    longint dv;
    longint d;
    longint m;
    longint r;
    longint k;
    longint v;
    n = keys_in_use;
    if (n < 1) n = 1;
    if (n > NKEYS) n = NKEYS;
    t0 = key_times[0];
    tl = key_times[n - 1];
    if (t >= t0 && t <= tl) return segment_value(n, t);
    early = (t < t0);
    mode = early ? mode_before : mode_after;
    span = tl - t0;
    dv = key_values[n - 1] - key_values[0];
    if (mode >= EXT_CYCLE && mode <= EXT_BOUNCE && span <= 0) mode = EXT_CONSTANT;
    if (mode == EXT_CONSTANT) return early ? key_values[0] : key_values[n - 1];
    if (mode == EXT_LINEAR) begin
      if (early) return key_values[0] - floor_shift(key_slopes_in[0] * (t0 - t));
      return key_values[n - 1] + floor_shift(key_slopes_out[n - 1] * (t - tl));
    end
    if (mode > EXT_BOUNCE) return 0;
    d = early ? (t0 - t) : (t - tl);
    if (mode == EXT_BOUNCE) begin
      m = d % (2 * span);
      if (early) return segment_value(n, (m <= span) ? t0 + m : t0 + 2 * span - m);
      return segment_value(n, (m <= span) ? tl - m : tl - (2 * span - m));
    end
    r = d % span;
    k = d / span + ((r != 0) ? 1 : 0);
    if (early) begin
      v = segment_value(n, (r == 0) ? t0 : t0 + span - r);
      return (mode == EXT_CYCLE_OFFSET) ? v - span_offset(k, dv) : v;
    end
    v = segment_value(n, (r == 0) ? tl : t0 + r);
    return (mode == EXT_CYCLE_OFFSET) ? v + span_offset(k, dv) : v;
  endfunction

  task automatic apply_request(kce_in_t r);
    kce_out_t res;
    longint   v;
    if (r.command == CMD_LOAD) begin
      key_times[r.key_index] = longint'(r.key_time);
      key_values[r.key_index] = longint'(r.key_value);
      key_slopes_in[r.key_index] = longint'(r.slope_in);
      key_slopes_out[r.key_index] = longint'(r.slope_out);
      key_coefs[r.key_index][0] = longint'(r.cubic_a);
      key_coefs[r.key_index][1] = longint'(r.square_b);
      key_coefs[r.key_index][2] = longint'(r.linear_c);
      key_coefs[r.key_index][3] = longint'(r.offset_d);
    end else begin
      v = curve_value_at(longint'(r.query_time));
      res.saturated = 1'b0;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        res.saturated = 1'b1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        res.saturated = 1'b1;
      end
      res.curve_value = v[31:0];
      expected_values = {expected_values, res};
    end
  endtask

  task automatic send_request(kce_in_t r);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    apply_request(r);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic load_key(int slot, logic [31:0] t);
    kce_in_t r;
    r = '0;
    r.command = CMD_LOAD;
    r.key_index = 6'(slot);
    r.key_time = t;
    r.key_value = random_word();
    r.slope_in = random_word();
    r.slope_out = random_word();
    r.cubic_a = random_word();
    r.square_b = random_word();
    r.linear_c = random_word();
    r.offset_d = random_word();
    r.query_time = $urandom;
    send_request(r);
  endtask

  // Shapes: 0 ascending, 1 ascending with repeated times, 2 unsorted, 3 all at one time.
  task automatic load_curve(int n, int shape);
    logic [31:0] t;
    t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    for (int i = 0; i < n; i++) begin
      load_key(i, (shape == 2) ? $urandom : t);
      if (shape == 0 || (shape == 1 && $urandom_range(0, 2) != 0))
        t = t + (($urandom_range(0, 15) == 0) ? $urandom_range(1, 32'h0100_0000)
                                               : $urandom_range(1, 32'h0004_0000));
    end
  endtask

  task automatic evaluate_at(logic [31:0] t);
    kce_in_t r;
    r = '0;
    r.command = CMD_EVALUATE;
    r.key_index = 6'($urandom);
    r.key_time = $urandom;
    r.key_value = $urandom;
    r.slope_in = $urandom;
    r.slope_out = $urandom;
    r.cubic_a = $urandom;
    r.square_b = $urandom;
    r.linear_c = $urandom;
    r.offset_d = $urandom;
    r.query_time = t;
    send_request(r);
  endtask

  function automatic logic [31:0] pick_query();
    int     n;
    longint t0;
    longint tl;
    longint span;
    longint reach;
    longint q;
    n = (keys_in_use < 1) ? 1 : ((keys_in_use > NKEYS) ? NKEYS : keys_in_use);
    t0 = key_times[0];
    tl = key_times[n - 1];
    span = tl - t0;
    reach = (span > 0) ? 4 * span + 5 : 64'sd200000;
    case ($urandom_range(0, 7))
      0: q = key_times[$urandom_range(0, n - 1)];
      1, 2: q = t0 + ((span > 0) ? longint'($urandom) % (span + 1) : 0);
      3: q = t0 - 1 - longint'($urandom) % reach;
      4: q = tl + 1 + longint'($urandom) % reach;
      5: q = t0 - span * $urandom_range(1, 5);
      6: q = tl + span * $urandom_range(1, 5);
      default: q = longint'($urandom);
    endcase
    return q[31:0];
  endfunction

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_values.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int value);
    settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_EXTRAP_BEFORE) mode_before = value & 7;
    else if (idx == CFG_EXTRAP_AFTER) mode_after = value & 7;
    else if (idx == CFG_KEY_COUNT) keys_in_use = value & 127;
  endtask

  task automatic test_directed();
    load_curve(NKEYS, 0);
    write_register(CFG_KEY_COUNT, 4);
    evaluate_at(32'(key_times[2]));
    evaluate_at(32'(key_times[0] + 1));
    evaluate_at(32'(key_times[3] - 1));
    for (int m = EXT_CONSTANT; m <= 7; m += (m == EXT_BOUNCE) ? 3 : 1) begin
      write_register(CFG_EXTRAP_BEFORE, m);
      write_register(CFG_EXTRAP_AFTER, m);
      evaluate_at(32'(key_times[0] - 3 * (key_times[3] - key_times[0]) / 2));
      evaluate_at(32'h7FFF_FFFF);
    end
    write_register(CFG_KEY_COUNT, 0);
    evaluate_at(32'h8000_0000);
    write_register(CFG_KEY_COUNT, 100);
    evaluate_at(32'(key_times[63]));
    evaluate_at(pick_query());
  endtask

  task automatic test_extrapolation_sweep();
    for (int phase = 0; phase < 40; phase++) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? ((phase % 2) ? NKEYS : 1) : $urandom_range(2, 10);
      quiet = (phase % 7 == 3);
      write_register(CFG_EXTRAP_BEFORE,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
      write_register(CFG_EXTRAP_AFTER,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
      load_curve(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      write_register(CFG_KEY_COUNT, ($urandom_range(0, 19) == 0) ? $urandom_range(65, 127) : n);
      repeat (30) evaluate_at(pick_query());
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_hold_off();
    settle();
    hold_pending = 1'b1;
    quiet = 1'b1;
    repeat (20) evaluate_at(pick_query());
    quiet = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_pending) begin
      hold_pending <= 1'b0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    kce_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_data);
      end else begin
        want = expected_values.pop_front();
        if (out_data.curve_value !== want.curve_value || out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value %h sat %b, got value %h sat %b",
                     want.curve_value, want.saturated, out_data.curve_value, out_data.saturated);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mode_before = EXT_CONSTANT;
    mode_after = EXT_CONSTANT;
    keys_in_use = 1;
    foreach (key_times[i]) begin
      key_times[i] = 0;
      key_values[i] = 0;
      key_slopes_in[i] = 0;
      key_slopes_out[i] = 0;
      for (int j = 0; j < 4; j++) key_coefs[i][j] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_extrapolation_sweep();
    test_output_hold_off();
    settle();
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
